/* design/robot_command_mode_decoder_core_macros.svh */
// assertion macros for the robot command mode decoder checker
// no dependencies; included by the checker file
`ifndef ROBOT_COMMAND_MODE_DECODER_CORE_MACROS_SVH
`define ROBOT_COMMAND_MODE_DECODER_CORE_MACROS_SVH

// same-cycle implication, off while in reset
`define RCMD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rcmd check failed: same-cycle rule");

// next-cycle implication, off while in reset
`define RCMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rcmd check failed: next-cycle rule");

// next-cycle implication, also checked during reset
`define RCMD_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rcmd check failed: reset rule");

`endif

/* design/rcmd_pkg.sv */
// shared types and codes for the robot command mode decoder
// no dependencies; used by every rtl file of the block
package rcmd_pkg;

  localparam logic [7:0] CMD_SIGN   = 8'h01;
  localparam logic [7:0] CMD_MANUAL = 8'h11;
  localparam logic [7:0] CMD_MOVE   = 8'h12;
  localparam logic [7:0] CMD_AUTO   = 8'h21;
  localparam logic [7:0] CMD_ROUTE  = 8'h22;
  localparam logic [7:0] CMD_POINT  = 8'h23;

  localparam logic [7:0] ARG_OFF = 8'h00;
  localparam logic [7:0] ARG_ON  = 8'h01;
  localparam logic [7:0] ARG_MAX = 8'h03;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_IDLE   = 2'd1;
  localparam logic [1:0] MODE_MANUAL = 2'd2;
  localparam logic [1:0] MODE_AUTO   = 2'd3;

  localparam logic [1:0] SUB_NONE = 2'd0;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_UNEXPECTED = 2'd1;
  localparam logic [1:0] ST_BAD_DATA   = 2'd2;
  localparam logic [1:0] ST_BAD_ID     = 2'd3;

  typedef struct packed {
    logic [7:0]  cmd;
    logic [63:0] payload;
    logic [7:0]  tail_byte;
    logic        link_lost;
  } item_t;

  typedef struct packed {
    logic [1:0]  robot_mode;
    logic [1:0]  auto_sub_mode;
    logic [1:0]  status;
    logic        drive_updated;
    logic [31:0] drive_x_bits;
    logic [31:0] drive_y_bits;
    logic [6:0]  drive_speed;
    logic        drive_rotation;
  } result_t;

  // handshake between the input register and the result register
  typedef struct packed {
    logic advance;
  } flow_t;

endpackage

/* design/robot_command_mode_decoder_core.sv */
// top level of the robot command mode decoder
// depends on rcmd_pkg, rcmd_in_stage, rcmd_mode_unit, rcmd_out_stage
//
//   channel   ports                                  direction
//   in        in_valid/in_stall, cmd payload tail    message item in
//   out       out_valid/out_stall, mode status drive result item out
//
// one item per cycle sustained while out_stall is low; out_valid rises once the item reaches the result register
// the input register feeds a combinational decode into the result register
// mode and drive state update in the cycle the item moves into the result register
// reset clears both valid flags and the mode and drive state
// out_stall holds the result register; the input register takes one more item if empty, then stalls
module robot_command_mode_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_cmd,
  input  logic [63:0] in_payload,
  input  logic [7:0]  in_tail_byte,
  input  logic        in_link_lost,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_robot_mode,
  output logic [1:0]  out_auto_sub_mode,
  output logic [1:0]  out_status,
  output logic        out_drive_updated,
  output logic [31:0] out_drive_x_bits,
  output logic [31:0] out_drive_y_bits,
  output logic [6:0]  out_drive_speed,
  output logic        out_drive_rotation
);

  rcmd_pkg::item_t   item;
  rcmd_pkg::result_t result;
  rcmd_pkg::result_t res;
  rcmd_pkg::flow_t   flow;
  logic              item_valid;

  rcmd_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_payload   (in_payload),
    .in_tail_byte (in_tail_byte),
    .in_link_lost (in_link_lost),
    .advance      (flow.advance),
    .valid        (item_valid),
    .item         (item)
  );

  rcmd_mode_unit u_mode (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item),
    .fire   (flow.advance),
    .result (result)
  );

  rcmd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (item_valid),
    .flow      (flow),
    .result    (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_robot_mode     = res.robot_mode;
  assign out_auto_sub_mode  = res.auto_sub_mode;
  assign out_status         = res.status;
  assign out_drive_updated  = res.drive_updated;
  assign out_drive_x_bits   = res.drive_x_bits;
  assign out_drive_y_bits   = res.drive_y_bits;
  assign out_drive_speed    = res.drive_speed;
  assign out_drive_rotation = res.drive_rotation;

endmodule

/* design/rcmd_in_stage.sv */
// input register of the robot command mode decoder
// depends on rcmd_pkg
module rcmd_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_cmd,
  input  logic [63:0]         in_payload,
  input  logic [7:0]          in_tail_byte,
  input  logic                in_link_lost,
  input  logic                advance,
  output logic                valid,
  output rcmd_pkg::item_t     item
);

  logic            valid_r;
  logic            valid_nxt;
  rcmd_pkg::item_t item_r;
  logic            take;

  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{cmd: in_cmd, payload: in_payload, tail_byte: in_tail_byte,
                  link_lost: in_link_lost};
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

/* design/rcmd_mode_unit.sv */
// mode state and command decode of the robot command mode decoder
// depends on rcmd_pkg
module rcmd_mode_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  rcmd_pkg::item_t     item,
  input  logic                fire,
  output rcmd_pkg::result_t   result
);

  logic [1:0]  mode_r, mode_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic [31:0] x_r, x_nxt;
  logic [31:0] y_r, y_nxt;
  logic [6:0]  speed_r, speed_nxt;
  logic        rot_r, rot_nxt;
  logic [1:0]  status;
  logic        updated;
  logic [7:0]  arg;

  assign arg = item.payload[63:56];

  always_comb begin
    mode_nxt  = mode_r;
    sub_nxt   = sub_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    speed_nxt = speed_r;
    rot_nxt   = rot_r;
    status    = rcmd_pkg::ST_OK;
    updated   = 1'b0;
    if (item.link_lost) begin
      mode_nxt = rcmd_pkg::MODE_OFF;
      sub_nxt  = rcmd_pkg::SUB_NONE;
    end else begin
      case (item.cmd)
        rcmd_pkg::CMD_SIGN: begin
          if (arg == rcmd_pkg::ARG_OFF) begin
            if (mode_r == rcmd_pkg::MODE_OFF) status = rcmd_pkg::ST_UNEXPECTED;
            else mode_nxt = rcmd_pkg::MODE_OFF;
          end else if (arg == rcmd_pkg::ARG_ON) begin
            if (mode_r != rcmd_pkg::MODE_OFF) status = rcmd_pkg::ST_UNEXPECTED;
            else mode_nxt = rcmd_pkg::MODE_IDLE;
          end else begin
            status = rcmd_pkg::ST_BAD_DATA;
          end
        end
        rcmd_pkg::CMD_MANUAL: begin
          if (arg == rcmd_pkg::ARG_OFF) begin
            if (mode_r != rcmd_pkg::MODE_MANUAL) status = rcmd_pkg::ST_UNEXPECTED;
            else mode_nxt = rcmd_pkg::MODE_IDLE;
          end else if (arg == rcmd_pkg::ARG_ON) begin
            if (mode_r != rcmd_pkg::MODE_IDLE) status = rcmd_pkg::ST_UNEXPECTED;
            else mode_nxt = rcmd_pkg::MODE_MANUAL;
          end else begin
            status = rcmd_pkg::ST_BAD_DATA;
          end
        end
        rcmd_pkg::CMD_MOVE: begin
          if (mode_r == rcmd_pkg::MODE_MANUAL) begin
            x_nxt     = item.payload[63:32];
            y_nxt     = item.payload[31:0];
            speed_nxt = item.tail_byte[7:1];
            rot_nxt   = item.tail_byte[0];
            updated   = 1'b1;
          end else begin
            status = rcmd_pkg::ST_UNEXPECTED;
          end
        end
        rcmd_pkg::CMD_AUTO: begin
          if (arg == rcmd_pkg::ARG_OFF) begin
            if (mode_r != rcmd_pkg::MODE_AUTO || sub_r == rcmd_pkg::SUB_NONE) begin
              status = rcmd_pkg::ST_UNEXPECTED;
            end else begin
              sub_nxt  = rcmd_pkg::SUB_NONE;
              mode_nxt = rcmd_pkg::MODE_IDLE;
            end
          end else if (arg inside {[rcmd_pkg::ARG_ON:rcmd_pkg::ARG_MAX]}) begin
            if (mode_r == rcmd_pkg::MODE_AUTO || sub_r != rcmd_pkg::SUB_NONE) begin
              status = rcmd_pkg::ST_UNEXPECTED;
            end else begin
              sub_nxt  = arg[1:0];
              mode_nxt = rcmd_pkg::MODE_AUTO;
            end
          end else begin
            status = rcmd_pkg::ST_BAD_DATA;
          end
        end
        rcmd_pkg::CMD_ROUTE: begin
          if (arg > rcmd_pkg::ARG_ON) status = rcmd_pkg::ST_BAD_DATA;
        end
        rcmd_pkg::CMD_POINT: begin
          status = rcmd_pkg::ST_OK;
        end
        default: begin
          status = rcmd_pkg::ST_BAD_ID;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= rcmd_pkg::MODE_OFF;
      sub_r   <= rcmd_pkg::SUB_NONE;
      x_r     <= '0;
      y_r     <= '0;
      speed_r <= '0;
      rot_r   <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      sub_r   <= sub_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      speed_r <= speed_nxt;
      rot_r   <= rot_nxt;
    end
  end

  assign result = '{robot_mode: mode_nxt, auto_sub_mode: sub_nxt, status: status,
                    drive_updated: updated, drive_x_bits: x_nxt, drive_y_bits: y_nxt,
                    drive_speed: speed_nxt, drive_rotation: rot_nxt};

endmodule

/* design/rcmd_out_stage.sv */
// result register of the robot command mode decoder
// depends on rcmd_pkg
module rcmd_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                src_valid,
  output rcmd_pkg::flow_t     flow,
  input  rcmd_pkg::result_t   result,
  output logic                out_valid,
  input  logic                out_stall,
  output rcmd_pkg::result_t   res
);

  logic              valid_r;
  logic              valid_nxt;
  rcmd_pkg::result_t res_r;
  logic              room;

  assign room         = !valid_r || !out_stall;
  assign flow.advance = src_valid && room;

  always_comb begin
    valid_nxt = valid_r;
    if (flow.advance) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (flow.advance) begin
      res_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign res       = res_r;

endmodule

/* design/rcmd_checker.sv */
// port-level checks for the robot command mode decoder, bound to the top level
// depends on rcmd_pkg and robot_command_mode_decoder_core_macros.svh
`include "robot_command_mode_decoder_core_macros.svh"

module rcmd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_robot_mode,
  input logic [1:0]  out_auto_sub_mode,
  input logic [1:0]  out_status,
  input logic        out_drive_updated,
  input logic [31:0] out_drive_x_bits
);

  // a held result keeps its mode and drive value
  `RCMD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_robot_mode) && $stable(out_drive_x_bits))

  // a new drive command only comes from a good move in manual mode
  `RCMD_ASSERT_NOW(a_drive_manual, clk, rst_n, out_valid && out_drive_updated, out_robot_mode == rcmd_pkg::MODE_MANUAL && out_status == rcmd_pkg::ST_OK)

  // automatic mode always carries a sub-mode
  `RCMD_ASSERT_NOW(a_auto_sub, clk, rst_n, out_valid && out_robot_mode == rcmd_pkg::MODE_AUTO, out_auto_sub_mode != rcmd_pkg::SUB_NONE)

  // no result right after reset
  `RCMD_ASSERT_RST(a_reset, clk, !rst_n, !out_valid)

endmodule

bind robot_command_mode_decoder_core rcmd_checker u_rcmd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_robot_mode    (out_robot_mode),
  .out_auto_sub_mode (out_auto_sub_mode),
  .out_status        (out_status),
  .out_drive_updated (out_drive_updated),
  .out_drive_x_bits  (out_drive_x_bits)
);
